FILE: sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, codes and reset values for the bladder pressure sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int PRESSURE_W = 16;
    localparam int TIME_W     = 32;
    localparam int HOLD_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFLATE_TARGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS        = 2'd2;

    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_CYCLE   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [PRESSURE_W-1:0] pressure;
        logic                  estop_switch;
        logic                  connected;
        logic [TIME_W-1:0]     time_ms;
        logic                  cmd_valid;
        logic                  cmd_free_run;
        logic                  cmd_cycle_run;
        logic                  cmd_inflate;
        logic                  cmd_deflate;
        logic                  cmd_start;
        logic                  cmd_stop;
    } bps_in_t;

    typedef struct packed {
        mode_t             run_mode;
        logic              req_inflate;
        logic              req_deflate;
        logic              req_start;
        logic              req_stop;
        logic              hold_armed;
        logic [TIME_W-1:0] hold_start;
        logic              estop_latched;
        logic              estop_deflated;
        logic              inflate_done;
        logic              deflate_done;
        logic              cycle_first;
        logic              free_first;
        logic              inflate_pin;
        logic              deflate_pin;
        logic              valve_pin;
    } bps_state_t;

    localparam bps_state_t STATE_RESET = '{
        run_mode:       MODE_STANDBY,
        req_inflate:    1'b0,
        req_deflate:    1'b0,
        req_start:      1'b0,
        req_stop:       1'b0,
        hold_armed:     1'b1,
        hold_start:     '0,
        estop_latched:  1'b0,
        estop_deflated: 1'b0,
        inflate_done:   1'b0,
        deflate_done:   1'b0,
        cycle_first:    1'b1,
        free_first:     1'b1,
        inflate_pin:    1'b0,
        deflate_pin:    1'b0,
        valve_pin:      1'b0
    };

endpackage

FILE: sv/bps_step.sv
// ----------------------------------------------------------------------------
// bps_step
// Next-state logic of the sequencer for one input word.
// ----------------------------------------------------------------------------
module bps_step (
    input  bps_pkg::bps_state_t                state_i,
    input  bps_pkg::bps_in_t                   word_i,
    input  logic [bps_pkg::PRESSURE_W-1:0]     inflate_target,
    input  logic [bps_pkg::PRESSURE_W-1:0]     deflate_target,
    input  logic [bps_pkg::HOLD_W-1:0]         hold_ms,
    output bps_pkg::bps_state_t                state_o
);

    function automatic bps_pkg::bps_state_t all_off(bps_pkg::bps_state_t s);
        bps_pkg::bps_state_t r;
        r = s;
        r.inflate_pin = 1'b0;
        r.deflate_pin = 1'b0;
        r.valve_pin   = 1'b0;
        return r;
    endfunction

    function automatic bps_pkg::bps_state_t deflate_step(bps_pkg::bps_state_t s,
                                                          logic below);
        bps_pkg::bps_state_t r;
        r = s;
        if (!below) begin
            r.inflate_pin = 1'b0;
            r.valve_pin   = 1'b1;
            r.deflate_pin = 1'b1;
        end else begin
            r.valve_pin   = 1'b0;
            r.deflate_pin = 1'b0;
        end
        return r;
    endfunction

    // hold elapsed test, evaluated on the state before the inflate step
    function automatic logic inflate_fin(bps_pkg::bps_state_t s, logic above,
                                         logic [bps_pkg::TIME_W-1:0] now,
                                         logic [bps_pkg::HOLD_W-1:0] hms);
        logic [bps_pkg::TIME_W-1:0] elapsed;
        elapsed = now - s.hold_start;
        return above && !s.hold_armed &&
               (elapsed >= {{(bps_pkg::TIME_W-bps_pkg::HOLD_W){1'b0}}, hms});
    endfunction

    function automatic bps_pkg::bps_state_t inflate_step(bps_pkg::bps_state_t s,
                                                          logic above, logic fin,
                                                          logic [bps_pkg::TIME_W-1:0] now);
        bps_pkg::bps_state_t r;
        r = s;
        r.valve_pin = 1'b0;
        if (!above) begin
            r.inflate_pin = 1'b1;
        end else begin
            r.inflate_pin = 1'b0;
            if (s.hold_armed) begin
                r.hold_start = now;
                r.hold_armed = 1'b0;
            end else if (fin) begin
                r.hold_start = '0;
                r.hold_armed = 1'b1;
            end
        end
        return r;
    endfunction

    logic                below;
    logic                above;
    bps_pkg::bps_state_t st;

    assign below = word_i.pressure < deflate_target;
    assign above = word_i.pressure > inflate_target;

    always_comb begin
        st = state_i;
        if (word_i.connected) begin
            if (word_i.cmd_valid) begin
                st.req_inflate = word_i.cmd_inflate;
                st.req_deflate = word_i.cmd_deflate;
                st.req_start   = word_i.cmd_start;
                st.req_stop    = word_i.cmd_stop;
                if (word_i.cmd_free_run) begin
                    st.run_mode = bps_pkg::MODE_FREE;
                end else if (word_i.cmd_cycle_run) begin
                    st.run_mode = bps_pkg::MODE_CYCLE;
                end else begin
                    st.run_mode = bps_pkg::MODE_STANDBY;
                end
            end
            if (!word_i.estop_switch) begin
                st.estop_latched = 1'b1;
                if (!st.estop_deflated) begin
                    st = deflate_step(st, below);
                    st.estop_deflated = below;
                end else begin
                    st = all_off(st);
                end
            end else if (st.estop_latched) begin
                st.estop_latched  = 1'b0;
                st.estop_deflated = 1'b0;
                st.run_mode       = bps_pkg::MODE_STANDBY;
            end else begin
                case (st.run_mode)
                    bps_pkg::MODE_FREE: begin
                        if (st.free_first) begin
                            st = deflate_step(st, below);
                            st.deflate_done = 1'b0;
                            if (below) begin
                                st.free_first = 1'b0;
                            end
                        end else if (st.req_inflate) begin
                            st.inflate_done = inflate_fin(st, above, word_i.time_ms, hold_ms);
                            st = inflate_step(st, above, st.inflate_done, word_i.time_ms);
                            if (st.inflate_done) begin
                                st.req_deflate = 1'b1;
                                st.req_inflate = 1'b0;
                            end
                        end else if (st.req_deflate) begin
                            st = deflate_step(st, below);
                            st.deflate_done = below;
                            if (below) begin
                                st.req_deflate  = 1'b0;
                                st.inflate_done = 1'b0;
                                st.deflate_done = 1'b0;
                                st.free_first   = 1'b1;
                                st.run_mode     = bps_pkg::MODE_STANDBY;
                            end
                        end else begin
                            st.run_mode = bps_pkg::MODE_STANDBY;
                        end
                    end
                    bps_pkg::MODE_CYCLE: begin
                        if (st.req_start) begin
                            if (st.cycle_first) begin
                                st = deflate_step(st, below);
                                st.deflate_done = below;
                                if (below) begin
                                    st.cycle_first = 1'b0;
                                end
                            end else begin
                                if (st.deflate_done) begin
                                    st.inflate_done = inflate_fin(st, above, word_i.time_ms,
                                                                  hold_ms);
                                    st = inflate_step(st, above, st.inflate_done,
                                                      word_i.time_ms);
                                    st.deflate_done = !st.inflate_done;
                                end
                                if (st.inflate_done) begin
                                    st = deflate_step(st, below);
                                    st.deflate_done = below;
                                    st.inflate_done = !below;
                                end
                            end
                        end else if (st.req_stop) begin
                            st = deflate_step(st, below);
                            st.deflate_done = below;
                            if (below) begin
                                st.req_start    = 1'b0;
                                st.req_stop     = 1'b0;
                                st.deflate_done = 1'b0;
                                st.inflate_done = 1'b0;
                                st.cycle_first  = 1'b1;
                                st.run_mode     = bps_pkg::MODE_STANDBY;
                            end
                        end else begin
                            st.run_mode = bps_pkg::MODE_STANDBY;
                        end
                    end
                    default: begin
                        st = all_off(st);
                    end
                endcase
            end
        end else begin
            st = all_off(st);
        end
    end

    assign state_o = st;

endmodule

FILE: sv/bladder_pressure_sequencer_core.sv
// ----------------------------------------------------------------------------
// bladder_pressure_sequencer_core
// Inflate/deflate/valve sequencer driven by one pressure sample per word.
// ----------------------------------------------------------------------------
// One input word is taken per clock, while m_ready stays high, and yields
// exactly one result word. A word is captured in an input register, runs
// through the next-state logic and lands in the result register when the
// output is free; the sequencer state is updated at the same edge.
// Throughput is one word per cycle while m_ready stays high. Configuration
// (targets, hold time) is written on the cfg port only while no word is in
// flight; the user must keep to this, the block itself does not enforce it.
module bladder_pressure_sequencer_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bps_pkg::PRESSURE_W-1:0]      s_pressure,
    input  logic                                s_estop_switch,
    input  logic                                s_connected,
    input  logic [bps_pkg::TIME_W-1:0]          s_time_ms,
    input  logic                                s_cmd_valid,
    input  logic                                s_cmd_free_run,
    input  logic                                s_cmd_cycle_run,
    input  logic                                s_cmd_inflate,
    input  logic                                s_cmd_deflate,
    input  logic                                s_cmd_start,
    input  logic                                s_cmd_stop,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_inflate_motor,
    output logic                                m_deflate_motor,
    output logic                                m_valve,
    output logic [1:0]                          m_current_mode,
    output logic                                m_estop_active,
    output logic                                m_holding
);

    logic [bps_pkg::PRESSURE_W-1:0] inflate_target_reg;
    logic [bps_pkg::PRESSURE_W-1:0] deflate_target_reg;
    logic [bps_pkg::HOLD_W-1:0]     hold_ms_reg;

    bps_pkg::bps_in_t    in_reg;
    logic                in_valid_reg;
    bps_pkg::bps_state_t state_reg;
    bps_pkg::bps_state_t state_next;
    logic                m_valid_reg;
    logic                out_free;
    logic                advance;
    logic                s_accept;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflate_target_reg <= '0;
            deflate_target_reg <= '0;
            hold_ms_reg        <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bps_pkg::CFG_INFLATE_TARGET: begin
                    inflate_target_reg <= cfg_data[bps_pkg::PRESSURE_W-1:0];
                end
                bps_pkg::CFG_DEFLATE_TARGET: begin
                    deflate_target_reg <= cfg_data[bps_pkg::PRESSURE_W-1:0];
                end
                bps_pkg::CFG_HOLD_MS: begin
                    hold_ms_reg <= cfg_data[bps_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg.pressure      <= s_pressure;
            in_reg.estop_switch  <= s_estop_switch;
            in_reg.connected     <= s_connected;
            in_reg.time_ms       <= s_time_ms;
            in_reg.cmd_valid     <= s_cmd_valid;
            in_reg.cmd_free_run  <= s_cmd_free_run;
            in_reg.cmd_cycle_run <= s_cmd_cycle_run;
            in_reg.cmd_inflate   <= s_cmd_inflate;
            in_reg.cmd_deflate   <= s_cmd_deflate;
            in_reg.cmd_start     <= s_cmd_start;
            in_reg.cmd_stop      <= s_cmd_stop;
        end
    end

    bps_step u_step (
        .state_i        (state_reg),
        .word_i         (in_reg),
        .inflate_target (inflate_target_reg),
        .deflate_target (deflate_target_reg),
        .hold_ms        (hold_ms_reg),
        .state_o        (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bps_pkg::STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_inflate_motor <= state_next.inflate_pin;
            m_deflate_motor <= state_next.deflate_pin;
            m_valve         <= state_next.valve_pin;
            m_current_mode  <= state_next.run_mode;
            m_estop_active  <= state_next.estop_latched;
            m_holding       <= !state_next.hold_armed;
        end
    end

    a_valve_excludes_inflate: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.valve_pin |-> !state_reg.inflate_pin)
        else $error("valve open while inflate motor driven");

    a_disconnect_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_reg.connected) |=> (!m_inflate_motor && !m_deflate_motor && !m_valve))
        else $error("drives not off while disconnected");

    a_estop_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.connected && !in_reg.estop_switch) |=> m_estop_active)
        else $error("e-stop not latched");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a word");

endmodule
